// File: rtl/core/dnv_pkg.sv
package dnv_pkg;

    // Default saturation point of the name and label byte counters
    localparam int DNV_COUNT_LIMIT = 255;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;  // '.'
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;  // 'z'

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int LEN_W      = 8;

    typedef enum logic [0:0] {
        REG_MIN_LENGTH = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } dnv_reg_idx_t;

    typedef struct packed {
        logic name_valid;
        logic name_cheap;
    } dnv_result_t;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_vowel(input logic [7:0] c);
        return (c == 8'h61) || (c == 8'h65) || (c == 8'h69) ||
               (c == 8'h6F) || (c == 8'h75) || (c == 8'h79);
    endfunction

endpackage

// File: rtl/core/dnv_core.sv
module dnv_core
    import dnv_pkg::*;
#(
    parameter int COUNT_LIMIT = DNV_COUNT_LIMIT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       char_in,
    input  logic             last_char,
    input  logic [LEN_W-1:0] min_length,
    input  logic [LEN_W-1:0] max_length,
    output dnv_result_t      result
);

    localparam int CW   = $clog2(COUNT_LIMIT + 1);
    localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [CW-1:0] SAT = CW'(COUNT_LIMIT);

    logic [CW-1:0] total_count_reg, total_count_next;
    logic [CW-1:0] label_count_reg, label_count_next;
    logic          prev_let_dig_reg, prev_let_dig_next;
    logic          bad_seen_reg, bad_seen_next;
    logic          pod_seen_reg, pod_seen_next;
    logic          vowel_seen_reg, vowel_seen_next;

    logic          lower, digit, let_dig, dot;
    logic [CW-1:0] tot1, lab1;
    logic          prev1, bad1, bad_fin, pod1, vow1;
    logic [CMPW-1:0] min_x, max_x, lab_x, labc_x, tot_x;

    always_comb
    begin
        lower   = is_lower(char_in);
        digit   = is_digit(char_in);
        let_dig = lower | digit;
        dot     = (char_in == CHAR_DOT);
        min_x   = CMPW'(min_length);
        max_x   = CMPW'(max_length);
        labc_x  = CMPW'(label_count_reg);

        pod1 = pod_seen_reg | digit | dot | (char_in == CHAR_HYPHEN) |
               (char_in == CHAR_SLASH);
        vow1 = vowel_seen_reg | is_vowel(char_in);
        tot1 = (total_count_reg >= SAT) ? SAT : total_count_reg + 1'b1;

        if (dot)
        begin
            // a dot closes the current label
            bad1  = bad_seen_reg | (label_count_reg == '0) | (labc_x < min_x) |
                    !prev_let_dig_reg;
            lab1  = '0;
            prev1 = 1'b0;
        end
        else
        begin
            if (label_count_reg == '0)
                bad1 = bad_seen_reg | !lower;
            else
                bad1 = bad_seen_reg | (!let_dig && (char_in != CHAR_HYPHEN));
            prev1 = let_dig;
            lab1  = (label_count_reg >= SAT) ? SAT : label_count_reg + 1'b1;
        end

        lab_x   = CMPW'(lab1);
        tot_x   = CMPW'(tot1);
        bad_fin = bad1 | (lab1 == '0) | (lab_x < min_x) | !prev1 |
                  (tot_x < min_x) | (tot_x > max_x);

        result.name_valid = !bad_fin;
        result.name_cheap = pod1 | !vow1;

        total_count_next  = total_count_reg;
        label_count_next  = label_count_reg;
        prev_let_dig_next = prev_let_dig_reg;
        bad_seen_next     = bad_seen_reg;
        pod_seen_next     = pod_seen_reg;
        vowel_seen_next   = vowel_seen_reg;
        if (step)
        begin
            if (last_char)
            begin
                total_count_next  = '0;
                label_count_next  = '0;
                prev_let_dig_next = 1'b0;
                bad_seen_next     = 1'b0;
                pod_seen_next     = 1'b0;
                vowel_seen_next   = 1'b0;
            end
            else
            begin
                total_count_next  = tot1;
                label_count_next  = lab1;
                prev_let_dig_next = prev1;
                bad_seen_next     = bad1;
                pod_seen_next     = pod1;
                vowel_seen_next   = vow1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_count_reg  <= '0;
            label_count_reg  <= '0;
            prev_let_dig_reg <= 1'b0;
            bad_seen_reg     <= 1'b0;
            pod_seen_reg     <= 1'b0;
            vowel_seen_reg   <= 1'b0;
        end
        else
        begin
            total_count_reg  <= total_count_next;
            label_count_reg  <= label_count_next;
            prev_let_dig_reg <= prev_let_dig_next;
            bad_seen_reg     <= bad_seen_next;
            pod_seen_reg     <= pod_seen_next;
            vowel_seen_reg   <= vowel_seen_next;
        end
    end

endmodule

// File: rtl/core/dotted_name_validator.sv
// Dotted name validator.
// A name streams in one byte per word on the input channel (in_valid/in_stall,
// char_in, last_char); last_char marks the final byte. Exactly one result word
// (name_valid, name_cheap) leaves on the output channel (out_valid/out_stall)
// per name, after its last byte. Names are lowercase dotted labels; empty names
// must not be presented.
// A last byte is held in the input register, then its result is loaded into
// the result register, where out_valid goes high and the word can be taken
// (one input register, one result register).
// Throughput: one byte per cycle, sustained, while the output is not stalled;
// the per-byte checks are a few compares and saturating counters.
// Stall: a result waiting in the output register does not block bytes that
// produce no result; only when a finished result waits stalled and the next last byte
// is ready does in_stall rise, holding the input register.
// Reset: clears all name state, empties both registers, and loads min_length = 1
// and max_length = 63. Registers are written over the APB port at addresses 0
// (min_length) and 4 (max_length); the user must write them only while idle, as the block does not enforce it.
module dotted_name_validator
    import dnv_pkg::*;
#(
    parameter int COUNT_LIMIT = DNV_COUNT_LIMIT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            char_in,
    input  logic                  last_char,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  name_valid,
    output logic                  name_cheap
);

    // config registers
    logic [LEN_W-1:0] min_length_reg, max_length_reg;
    logic             cfg_wr;
    dnv_reg_idx_t     cfg_idx;

    // input register stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    logic       s1_adv, in_accept;

    // result register
    logic        out_valid_reg, out_valid_next;
    dnv_result_t out_data_reg;
    dnv_result_t core_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = dnv_reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_MIN_LENGTH: prdata = CFG_DATA_W'(min_length_reg);
            REG_MAX_LENGTH: prdata = CFG_DATA_W'(max_length_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= LEN_W'(1);
            max_length_reg <= LEN_W'(63);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MIN_LENGTH: min_length_reg <= pwdata[LEN_W-1:0];
                REG_MAX_LENGTH: max_length_reg <= pwdata[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // a word leaves stage 1 unless it would produce a result into a full,
    // stalled output register
    assign s1_adv    = s1_valid_reg & (!s1_last_reg | !out_valid_reg | !out_stall);
    assign in_stall  = s1_valid_reg & !s1_adv;
    assign in_accept = in_valid & !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_last_reg)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg <= char_in;
            s1_last_reg <= last_char;
        end
        if (s1_adv && s1_last_reg)
            out_data_reg <= core_res;
    end

    dnv_core #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_adv),
        .char_in    (s1_char_reg),
        .last_char  (s1_last_reg),
        .min_length (min_length_reg),
        .max_length (max_length_reg),
        .result     (core_res)
    );

    assign out_valid  = out_valid_reg;
    assign name_valid = out_data_reg.name_valid;
    assign name_cheap = out_data_reg.name_cheap;

    // stall back to the source only while stage 1 holds a word
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall with empty input register");

    // a new result only follows a last byte leaving stage 1
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_last_reg))
        else $error("result word without a last byte");

    // never overwrite a waiting, stalled result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(s1_adv && s1_last_reg))
        else $error("stalled result overwritten");

    // config write to min_length lands in that register
    a_cfg_min: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && cfg_idx == REG_MIN_LENGTH) |=>
            (min_length_reg == $past(pwdata[LEN_W-1:0])))
        else $error("min_length write lost");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import dnv_pkg::*;
();

    // ---------------------------------------------------------------
    // Clock, reset and the block's ports
    // ---------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            char_in = 8'h00;
    logic                  last_char = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  name_valid;
    logic                  name_cheap;

    dotted_name_validator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .name_valid(name_valid),
        .name_cheap(name_cheap)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake hangs.
    initial
    begin
        #3ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // Shared state of the bench
    // ---------------------------------------------------------------
    int tx_gap_pct   = 0;   // chance of the sender idling in a cycle
    int rx_stall_pct = 0;   // chance of stalling the output in a cycle
    int mismatch_count = 0;

    dnv_result_t expected_verdicts[$];   // verdicts still owed by the block
    logic [7:0]  name_bytes[$];          // name being built for sending

    // Mirror of the length registers, reset values
    int cfg_min_len = 1;
    int cfg_max_len = 63;

    // Mirror of the per-name scan state
    int nm_total = 0;       // bytes of the name, saturating
    int nm_label = 0;       // bytes of the open label, saturating
    bit nm_prev_alnum = 1'b0;
    bit nm_bad = 1'b0;
    bit nm_punct = 1'b0;    // digit, dot, hyphen or slash seen
    bit nm_vowel = 1'b0;

    task automatic report_mismatch(string what);
        $display("%0t ns  mismatch: %s", $time / 1ns, what);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic bit vowel_byte(logic [7:0] c);
        return c == "a" || c == "e" || c == "i" || c == "o" || c == "u" || c == "y";
    endfunction

    function automatic int bump_count(int v);
        return (v >= DNV_COUNT_LIMIT) ? DNV_COUNT_LIMIT : v + 1;
    endfunction

    // A label closes on a dot or at the end of the name. Empty labels
    // fail here too, even with the length floor at zero.
    function automatic void close_open_label();
        if (nm_label == 0 || nm_label < cfg_min_len || !nm_prev_alnum)
            nm_bad = 1'b1;
        nm_label = 0;
        nm_prev_alnum = 1'b0;
    endfunction

    function automatic void track_name_byte(logic [7:0] c, logic last);
        bit          lower;
        bit          digit;
        bit          alnum;
        dnv_result_t verdict;
        lower = (c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z);
        digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        alnum = lower || digit;

        if (digit || c == CHAR_DOT || c == CHAR_HYPHEN || c == CHAR_SLASH)
            nm_punct = 1'b1;
        if (vowel_byte(c))
            nm_vowel = 1'b1;
        nm_total = bump_count(nm_total);

        if (c == CHAR_DOT)
            close_open_label();
        else
        begin
            // first byte of a label must be a letter; later ones letter,
            // digit or hyphen
            if (nm_label == 0)
            begin
                if (!lower)
                    nm_bad = 1'b1;
            end
            else if (!alnum && c != CHAR_HYPHEN)
                nm_bad = 1'b1;
            nm_prev_alnum = alnum;
            nm_label = bump_count(nm_label);
        end

        if (last)
        begin
            close_open_label();
            if (nm_total < cfg_min_len || nm_total > cfg_max_len)
                nm_bad = 1'b1;
            verdict.name_valid = !nm_bad;
            verdict.name_cheap = nm_punct || !nm_vowel;
            expected_verdicts.push_back(verdict);
            nm_total = 0;
            nm_label = 0;
            nm_prev_alnum = 1'b0;
            nm_bad = 1'b0;
            nm_punct = 1'b0;
            nm_vowel = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Output side: random stall, and each accepted word is checked
    // against the oldest outstanding verdict. Values read here are the
    // ones from before the edge.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : verdict_check
        dnv_result_t want;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch($sformatf("unexpected word valid=%0b cheap=%0b",
                                              name_valid, name_cheap));
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (name_valid !== want.name_valid)
                        report_mismatch($sformatf("name_valid %0b, want %0b",
                                                  name_valid, want.name_valid));
                    if (name_cheap !== want.name_cheap)
                        report_mismatch($sformatf("name_cheap %0b, want %0b",
                                                  name_cheap, want.name_cheap));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Sends one word and returns in the time step of its acceptance.
    // The valid stays high so the next word can follow back to back.
    task automatic send_byte(logic [7:0] c, logic last);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_in   <= c;
        last_char <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_name_byte(c, last);
    endtask

    task automatic send_name();
        foreach (name_bytes[i])
            send_byte(name_bytes[i], i == name_bytes.size() - 1);
    endtask

    task automatic send_text(string s);
        name_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            name_bytes.push_back(s[i]);
        send_name();
    endtask

    // Holds the input off until every verdict is in, then lets the
    // two-stage pipe settle.
    task automatic wait_drained();
        int n;
        n = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (expected_verdicts.size() != 0 && n < 5000);
        if (expected_verdicts.size() != 0)
        begin
            report_mismatch($sformatf("%0d verdicts never arrived",
                                      expected_verdicts.size()));
            expected_verdicts.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    task automatic apb_access(dnv_reg_idx_t idx, bit wr, logic [7:0] val);
        int want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        // upper data bits are random; only the low byte is kept
        pwdata  <= (CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(8'hFF)) | CFG_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        want = (idx == REG_MIN_LENGTH) ? cfg_min_len : cfg_max_len;
        if (wr)
        begin
            if (idx == REG_MIN_LENGTH)
                cfg_min_len = val;
            else
                cfg_max_len = val;
        end
        else if (prdata[7:0] !== 8'(want))
            report_mismatch($sformatf("%s reads %0d, want %0d",
                                      idx.name(), prdata[7:0], want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes both limits while the block is idle and reads them back.
    task automatic set_lengths(int lo, int hi);
        wait_drained();
        apb_access(REG_MIN_LENGTH, 1'b1, 8'(lo));
        apb_access(REG_MAX_LENGTH, 1'b1, 8'(hi));
        apb_access(REG_MIN_LENGTH, 1'b0, 8'h00);
        apb_access(REG_MAX_LENGTH, 1'b0, 8'h00);
    endtask

    // ---------------------------------------------------------------
    // Name builders
    // ---------------------------------------------------------------
    function automatic logic [7:0] pick_letter(bit no_vowel);
        logic [7:0] c;
        do
            c = CHAR_LOW_A + 8'($urandom_range(25));
        while (no_vowel && vowel_byte(c));
        return c;
    endfunction

    // One label of len_a letters, or two labels joined by a dot when
    // len_b is nonzero.
    task automatic send_long(int len_a, int len_b);
        name_bytes.delete();
        repeat (len_a) name_bytes.push_back(pick_letter(1'b0));
        if (len_b > 0)
        begin
            name_bytes.push_back(CHAR_DOT);
            repeat (len_b) name_bytes.push_back(pick_letter(1'b0));
        end
        send_name();
    endtask

    // Mostly well-formed dotted names with random content; some get one
    // byte spoiled, a few are raw noise.
    task automatic fill_random_name();
        int         kind;
        int         nlab;
        int         llen;
        int         r;
        bit         no_vowel;
        bit         plain;
        logic [7:0] c;
        name_bytes.delete();
        kind = $urandom_range(99);
        if (kind >= 88)
        begin
            repeat ($urandom_range(1, 6)) name_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        no_vowel = ($urandom_range(4) == 0);
        plain    = ($urandom_range(3) == 0);   // letters only, one label
        nlab     = plain ? 1 : $urandom_range(1, 3);
        for (int l = 0; l < nlab; l++)
        begin
            if (l > 0)
                name_bytes.push_back(CHAR_DOT);
            llen = $urandom_range(1, 9);
            for (int i = 0; i < llen; i++)
            begin
                r = $urandom_range(9);
                if (i == 0 || plain || r < 6)
                    c = pick_letter(no_vowel);
                else if (r < 8 || i == llen - 1)
                    c = CHAR_ZERO + 8'($urandom_range(9));
                else
                    c = CHAR_HYPHEN;
                name_bytes.push_back(c);
            end
        end
        if (kind >= 70)
        begin
            r = $urandom_range(name_bytes.size() - 1);
            case ($urandom_range(5))
                0:       name_bytes[r] = CHAR_DOT;
                1:       name_bytes[r] = CHAR_HYPHEN;
                2:       name_bytes[r] = "A" + 8'($urandom_range(25));
                3:       name_bytes[r] = CHAR_SLASH;
                4:       name_bytes[r] = 8'($urandom_range(255));
                default: name_bytes.push_back(CHAR_DOT);
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset limits (1..63): label rules, cheap flag, odd bytes.
    task automatic test_directed_words();
        send_text("a");       // valid, has a vowel, not cheap
        send_text("b");       // valid, no vowel so cheap
        send_text("z9");
        send_text(".");       // both labels empty
        send_text("a.b");
        send_text("a..b");    // doubled dot
        send_text("a.");      // trailing dot
        send_text("-a");      // label starts with hyphen
        send_text("a-");      // label ends with hyphen
        send_text("a-9");
        send_text("Ab");      // uppercase
        send_text("0");       // starts with digit
        send_text("y/");      // slash
        send_byte("a", 1'b0);
        send_byte(8'hFF, 1'b1);   // high byte
        send_byte(8'h00, 1'b1);   // control byte
    endtask

    // Limits at and past their stated range.
    task automatic test_register_extremes();
        set_lengths(0, 0);        // every name rejected
        send_text("a");
        send_text("ab.c");
        set_lengths(0, 63);       // no floor, empty labels still fail
        send_text("a");
        send_text("a..b");
        send_text(".b");
        set_lengths(1, 1);
        send_text("a");
        send_text("ab");
        set_lengths(3, 20);
        send_text("abc");
        send_text("abc.de");      // second label too short
        send_text("ab");
    endtask

    // A name and label past the counter limit.
    task automatic test_count_saturation();
        set_lengths(1, 255);
        send_long(256, 0);        // counts stop at the limit, so accepted
    endtask

    task automatic test_random_names(int lo, int hi, int n_bytes);
        int sent;
        int names;
        set_lengths(lo, hi);
        sent  = 0;
        names = 0;
        while (sent < n_bytes)
        begin
            fill_random_name();
            send_name();
            sent += name_bytes.size();
            names++;
            if (names % 12 == 0)
                wait_drained();   // pause until the output side catches up
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender rarely idles, receiver often stalls
        tx_gap_pct   = 10;
        rx_stall_pct = 56;
        test_directed_words();
        test_register_extremes();
        test_random_names(3, 20, 96);

        // and the other way round
        tx_gap_pct   = 56;
        rx_stall_pct = 10;
        test_count_saturation();
        test_random_names(2, 12, 96);

        // full rate both sides
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        test_random_names(1, 63, 96);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
